[hdl/ami_pkg.sv]
package ami_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    // widths of the exact intermediates
    localparam int COF_W  = 65;
    localparam int DET_W  = 99;
    localparam int NUM_W  = COF_W + 2 * FRAC_BITS + 1;
    localparam int QUO_W  = 33;
    localparam int ACC_W  = 67;
    // divider stages from request to quotient
    localparam int DIV_LAT = QUO_W + 2;

    typedef struct packed {
        logic signed [31:0] a00, a01, a02, a03;
        logic signed [31:0] a10, a11, a12, a13;
        logic signed [31:0] a20, a21, a22, a23;
    } t_in;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col0, col1, col2, col3;
        logic               singular;
        logic               last_row;
    } t_out;

    // clamp a signed value to the word range
    function automatic logic signed [31:0] sat_word(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        begin
            hi = (ACC_W'(1) <<< (WORD_BITS - 1)) - ACC_W'(1);
            lo = -hi - ACC_W'(1);
            if (v > hi) sat_word = 32'(hi);
            else if (v < lo) sat_word = 32'(lo);
            else sat_word = 32'(v);
        end
    endfunction

endpackage

[hdl/ami_cof.sv]
// cofactors over two stages, then determinant over three more
module ami_cof (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  ami_pkg::t_in         i_m,
    output logic                 o_vld,
    output logic signed [ami_pkg::COF_W-1:0] o_cof [9],
    output logic signed [ami_pkg::DET_W-1:0] o_det,
    output logic signed [31:0]   o_t [3]
);
    import ami_pkg::*;

    // width of a 32 by 33 bit partial product
    localparam int PP_W = 65;

    logic signed [31:0] m [9];
    logic signed [63:0] r_p [18];
    logic signed [31:0] r_m0 [3], r_t0 [3];
    logic signed [COF_W-1:0] r_c [9];
    logic signed [31:0] r_m1 [3], r_t1 [3];
    logic signed [PP_W-1:0] r_pl [3];
    logic signed [PP_W-1:0] r_ph [3];
    logic signed [COF_W-1:0] r_c2 [9];
    logic signed [31:0] r_t2 [3];
    logic signed [DET_W-1:0] r_d [3];
    logic signed [COF_W-1:0] r_c3 [9];
    logic signed [31:0] r_t3 [3];
    logic signed [DET_W-1:0] r_det;
    logic signed [COF_W-1:0] r_c4 [9];
    logic signed [31:0] r_t4 [3];
    logic [4:0] r_v;

    assign m = '{i_m.a00, i_m.a01, i_m.a02, i_m.a10, i_m.a11, i_m.a12,
                 i_m.a20, i_m.a21, i_m.a22};

    // index pairs for the cofactor products, p*q - r*s
    localparam int IDX [36] = '{4,8,7,5, 7,2,1,8, 1,5,4,2, 6,5,3,8, 0,8,6,2,
                                3,2,0,5, 3,7,6,4, 6,1,0,7, 0,4,3,1};

    always_ff @(posedge i_clk) begin
        // stage 1: products
        for (int k = 0; k < 9; k++) begin
            r_p[2*k]   <= 64'(m[IDX[4*k]]) * 64'(m[IDX[4*k+1]]);
            r_p[2*k+1] <= 64'(m[IDX[4*k+2]]) * 64'(m[IDX[4*k+3]]);
        end
        r_m0 <= '{i_m.a00, i_m.a01, i_m.a02};
        r_t0 <= '{i_m.a03, i_m.a13, i_m.a23};
        // stage 2: differences
        for (int k = 0; k < 9; k++)
            r_c[k] <= COF_W'(r_p[2*k]) - COF_W'(r_p[2*k+1]);
        r_m1 <= r_m0;
        r_t1 <= r_t0;
        // stage 3: row-0 entries times low word and high part of cofactor column 0
        for (int k = 0; k < 3; k++) begin
            r_pl[k] <= PP_W'(r_m1[k]) * PP_W'($signed({1'b0, r_c[3*k][31:0]}));
            r_ph[k] <= PP_W'(r_m1[k]) * PP_W'($signed(r_c[3*k][COF_W-1:32]));
        end
        r_c2 <= r_c;
        r_t2 <= r_t1;
        // stage 4: join the two halves of each product
        for (int k = 0; k < 3; k++)
            r_d[k] <= (DET_W'(r_ph[k]) <<< 32) + DET_W'(r_pl[k]);
        r_c3 <= r_c2;
        r_t3 <= r_t2;
        // stage 5: determinant sum
        r_det <= r_d[0] + r_d[1] + r_d[2];
        r_c4  <= r_c3;
        r_t4  <= r_t3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[3:0], i_vld};
    end

    assign o_vld = r_v[4];
    assign o_cof = r_c4;
    assign o_det = r_det;
    assign o_t   = r_t4;

endmodule

[hdl/ami_div.sv]
// one rounded quotient per cycle: |n|*2^33+|d| over 2*|d|, one bit per stage
module ami_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic signed [ami_pkg::COF_W-1:0] i_cof,
    input  logic signed [ami_pkg::DET_W-1:0] i_det,
    input  logic [3:0]           i_tag,
    output logic                 o_vld,
    output logic signed [31:0]   o_q,
    output logic [3:0]           o_tag
);
    import ami_pkg::*;

    localparam int NB = NUM_W + 1;
    localparam int DB = DET_W + 1;
    localparam int S  = DIV_LAT - 1;

    logic [NB-1:0] r_n [S+1];
    logic [DB-1:0] r_d [S+1];
    logic [DB:0]   r_r [S+1];
    logic [S-1:0]  r_q [S+1];
    logic          r_neg [S+1];
    logic          r_big [S+1];
    logic [3:0]    r_tag [S+1];
    logic [S:0]    r_v;

    logic [NUM_W-1:0] an;
    logic [DET_W-1:0] ad;
    logic [NB-1:0]    num0;
    logic [DB-1:0]    den0;

    always_comb begin
        an = i_cof[COF_W-1] ? NUM_W'(-i_cof) : NUM_W'(i_cof);
        ad = i_det[DET_W-1] ? DET_W'(-i_det) : DET_W'(i_det);
        num0 = NB'({1'b0, an} << (2 * FRAC_BITS + 1)) + NB'(ad);
        den0 = {ad, 1'b0};
    end

    // entry: the quotient's upper bits only flag overflow
    always_ff @(posedge i_clk) begin
        r_n[0]   <= num0;
        r_d[0]   <= den0;
        r_r[0]   <= (DB+1)'(num0 >> S);
        r_q[0]   <= '0;
        r_neg[0] <= i_cof[COF_W-1] ^ i_det[DET_W-1];
        r_big[0] <= (num0 >> S) >= NB'(den0);
        r_tag[0] <= i_tag;
        for (int k = 0; k < S; k++) begin
            logic [DB:0] t;
            t = {r_r[k][DB-1:0], r_n[k][S-1-k]};
            r_n[k+1]   <= r_n[k];
            r_d[k+1]   <= r_d[k];
            r_neg[k+1] <= r_neg[k];
            r_big[k+1] <= r_big[k];
            r_tag[k+1] <= r_tag[k];
            if (t >= (DB+1)'(r_d[k])) begin
                r_r[k+1] <= t - (DB+1)'(r_d[k]);
                r_q[k+1] <= {r_q[k][S-2:0], 1'b1};
            end else begin
                r_r[k+1] <= t;
                r_q[k+1] <= {r_q[k][S-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[S-1:0], i_vld};
    end

    // sign and saturate
    logic signed [ACC_W-1:0] qs;
    always_comb begin
        qs = r_big[S] ? (ACC_W'(1) <<< 40) : ACC_W'(r_q[S]);
        if (r_neg[S]) qs = -qs;
    end

    assign o_q   = sat_word(qs);
    assign o_vld = r_v[S];
    assign o_tag = r_tag[S];

endmodule

[hdl/affine_matrix_inverse.sv]
// Affine 3x4 inverse, Q16.16. Raise start with the matrix while busy is low;
// busy then stays high while r_gap counts down, so new matrices are spaced no
// closer than the time their three result rows need on the single output port.
// Row 0 is on o_result, marked by o_valid, after the cofactor stages, the row
// step, the 35-stage divider (one per column, turning cofactors into rounded
// quotients), the quotient, product, sum and output registers; rows 1 and 2
// follow right behind it. The receiver cannot stall, so take the rows as they
// come. A zero determinant gives zero entries with singular set on all three rows.
module affine_matrix_inverse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ami_pkg::t_in  i_item,
    output logic          busy,
    output logic          o_valid,
    output ami_pkg::t_out o_result
);
    import ami_pkg::*;

    logic [1:0] r_gap;
    logic       acc;
    assign busy = (r_gap != 2'd0);
    assign acc  = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_gap <= '0;
        else if (acc)  r_gap <= 2'd2;
        else if (busy) r_gap <= r_gap - 2'd1;
    end

    logic                    c_vld;
    logic signed [COF_W-1:0] c_cof [9];
    logic signed [DET_W-1:0] c_det;
    logic signed [31:0]      c_t [3];

    ami_cof u_cof (.i_clk, .i_rst_n, .i_vld(acc), .i_m(i_item),
                   .o_vld(c_vld), .o_cof(c_cof), .o_det(c_det), .o_t(c_t));

    // hold the item while its three rows are issued
    logic signed [COF_W-1:0] r_cof [9];
    logic signed [DET_W-1:0] r_det;
    logic signed [31:0]      r_t [3];
    logic                    r_sq;
    logic [1:0]              r_row;
    logic                    r_run;

    always_ff @(posedge i_clk) begin
        if (c_vld) begin
            r_cof <= c_cof;
            r_det <= c_det;
            r_t   <= c_t;
            r_sq  <= (c_det == '0);
        end
    end

    // step through the rows, one a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_row <= '0;
        end else if (c_vld) begin
            r_run <= 1'b1;
            r_row <= '0;
        end else if (r_run) begin
            if (r_row == 2'd2) begin
                r_run <= 1'b0;
                r_row <= '0;
            end else begin
                r_row <= r_row + 2'd1;
            end
        end
    end

    // pick the three cofactors of the current row
    logic signed [COF_W-1:0] s_cof [3];
    always_comb begin
        case (r_row)
            2'd0:    s_cof = '{r_cof[0], r_cof[1], r_cof[2]};
            2'd1:    s_cof = '{r_cof[3], r_cof[4], r_cof[5]};
            default: s_cof = '{r_cof[6], r_cof[7], r_cof[8]};
        endcase
    end

    // one divider per column; tag = row, col
    logic signed [31:0] d_q [3];
    logic [3:0]         d_tag [3];
    logic               d_vld [3];

    for (genvar j = 0; j < 3; j++) begin : g_div
        ami_div u_div (.i_clk, .i_rst_n, .i_vld(r_run), .i_cof(s_cof[j]),
                       .i_det(r_det), .i_tag({r_row, 2'(j)}),
                       .o_vld(d_vld[j]), .o_q(d_q[j]), .o_tag(d_tag[j]));
    end

    // carry t and singular through the divider delay with the row
    logic signed [31:0] r_tl [DIV_LAT][3];
    logic               r_sl [DIV_LAT];
    always_ff @(posedge i_clk) begin
        r_tl[0] <= r_t;
        r_sl[0] <= r_sq;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_tl[i] <= r_tl[i-1];
            r_sl[i] <= r_sl[i-1];
        end
    end

    // register the quotients with their row
    logic signed [31:0] r_inv1 [3];
    logic signed [31:0] r_tp [3];
    logic               r_s1;
    logic [1:0]         r_row1;
    always_ff @(posedge i_clk) begin
        r_inv1 <= d_q;
        r_tp   <= r_tl[DIV_LAT-1];
        r_s1   <= r_sl[DIV_LAT-1];
        r_row1 <= d_tag[0][3:2];
    end

    // products with t
    logic signed [63:0] r_pr [3];
    logic signed [31:0] r_inv2 [3];
    logic               r_s2;
    logic [1:0]         r_row2;
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++)
            r_pr[j] <= 64'(r_inv1[j]) * 64'(r_tp[j]);
        r_inv2 <= r_inv1;
        r_s2   <= r_s1;
        r_row2 <= r_row1;
    end

    // negated sum of the products
    logic signed [ACC_W-1:0] r_nsum;
    logic signed [31:0]      r_inv3 [3];
    logic                    r_s3;
    logic [1:0]              r_row3;
    always_ff @(posedge i_clk) begin
        r_nsum <= -(ACC_W'(r_pr[0]) + ACC_W'(r_pr[1]) + ACC_W'(r_pr[2]));
        r_inv3 <= r_inv2;
        r_s3   <= r_s2;
        r_row3 <= r_row2;
    end

    // valid bits alongside the data
    logic r_v1, r_v2, r_v3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= d_vld[0];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // round to nearest, ties away from zero
    logic signed [ACC_W-1:0] rnd, rq;
    always_comb begin
        rnd = r_nsum[ACC_W-1] ? ACC_W'((1 << (FRAC_BITS-1)) - 1)
                              : ACC_W'(1 << (FRAC_BITS-1));
        rq  = (r_nsum + rnd) >>> FRAC_BITS;
    end

    // saturate and present
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_v3;
        o_result.row_index <= r_row3;
        o_result.col0      <= r_s3 ? '0 : r_inv3[0];
        o_result.col1      <= r_s3 ? '0 : r_inv3[1];
        o_result.col2      <= r_s3 ? '0 : r_inv3[2];
        o_result.col3      <= r_s3 ? '0 : sat_word(rq);
        o_result.singular  <= r_s3;
        o_result.last_row  <= (r_row3 == 2'd2);
    end

    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> busy) else $error("busy not raised after request");
    a_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.row_index != 2'd3) else $error("bad row");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.last_row |-> o_result.row_index == 2'd2)
        else $error("last row mismatch");
    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_vld[0] |-> d_vld[1] && d_vld[2] && d_tag[0][1:0] == 2'd0
                     && d_tag[1] == {d_tag[0][3:2], 2'd1}
                     && d_tag[2] == {d_tag[0][3:2], 2'd2})
        else $error("divider lanes out of step");

endmodule
